FILE: src/sliding_window_rate_limiter_macros.svh
// Assertion macros shared by the rate limiter RTL.
`ifndef SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWRL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/swrl_pkg.sv
// Types and constants for the sliding-window rate limiter.
package swrl_pkg;

    // Default sizes
    localparam int LOG_DEPTH_DEF = 32;
    localparam int TIME_BITS_DEF = 48;

    // Register file layout
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int LIMIT_W     = 6;
    localparam int COUNT_OUT_W = 6;
    localparam int M_DATA_W    = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_UPLOAD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_QUERY  = 2'd2;

    // Reset values
    localparam logic [CFG_DATA_W-1:0] WINDOW_MS_RST    = 32'd60000;
    localparam logic [LIMIT_W-1:0]    LIMIT_UPLOAD_RST = 6'd9;
    localparam logic [LIMIT_W-1:0]    LIMIT_QUERY_RST  = 6'd19;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_CHECK,
        ST_FINISH
    } state_t;

endpackage

FILE: src/sliding_window_rate_limiter.sv
// Flow: an accepted request word passes PREP, a SCAN/CHECK head scan of log 0 and then of log 1,
// and FINISH. Each scan examines every expired head stamp, plus at most one kept stamp per log;
// the stamp memory read port sets its pace, one head entry read and compared per cycle. A new request
// is taken in IDLE, once the last result word is registered; a pending result does not block it.
// Reset: both logs emptied, window 60000 ms, limits 9 and 19; stamp memory is not cleared.
`include "sliding_window_rate_limiter_macros.svh"

module sliding_window_rate_limiter #(
    parameter int LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF,
    parameter int TIME_BITS = swrl_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]      s_tdata,   // [TIME_BITS-1:0] now_ms
    input  logic                                s_tuser,   // [0] category
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swrl_pkg::M_DATA_W-1:0]       m_tdata,   // [0] granted, [6:1] count_in_window
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
    localparam int ADDR_W  = $clog2(2 * LOG_DEPTH);
    localparam int CMP_W   = (CNT_W > swrl_pkg::LIMIT_W) ? CNT_W : swrl_pkg::LIMIT_W;
    localparam int DIFF_W  = (TIME_BITS > swrl_pkg::CFG_DATA_W) ? TIME_BITS
                                                                : swrl_pkg::CFG_DATA_W;
    localparam int SUM_W   = IDX_W + 1;

    // ------------------------------------------------------------------
    // Registers
    swrl_pkg::state_t state_reg, state_next;

    logic [swrl_pkg::CFG_DATA_W-1:0] window_reg;
    logic [swrl_pkg::LIMIT_W-1:0]    lim_up_reg;
    logic [swrl_pkg::LIMIT_W-1:0]    lim_qy_reg;

    logic [IDX_W-1:0]     head_reg  [2];
    logic [CNT_W-1:0]     count_reg [2];

    logic                 cat_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] thresh_reg;
    logic                 exp_en_reg;
    logic                 scan_reg;

    logic                 m_valid_reg;
    logic                 m_granted_reg;
    logic [swrl_pkg::COUNT_OUT_W-1:0] m_count_reg;

    // Stamp memory, both logs: category c owns slots c*LOG_DEPTH and up
    logic [TIME_BITS-1:0] stamp_mem [0:2*LOG_DEPTH-1];
    logic [TIME_BITS-1:0] rd_data_reg;

    // ------------------------------------------------------------------
    // Datapath helpers
    logic [IDX_W-1:0]  scan_head;
    logic [CNT_W-1:0]  scan_cnt;
    logic [IDX_W-1:0]  head_inc;
    logic              stale;

    logic [IDX_W-1:0]  sel_head;
    logic [CNT_W-1:0]  sel_cnt;
    logic [swrl_pkg::LIMIT_W-1:0] sel_limit;
    logic              grant;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_idx;

    logic [DIFF_W:0]   diff;

    // Control
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic              pop;
    logic              scan_done;
    logic              emit;
    logic              out_free;

    // Scanned log and requested log views
    assign scan_head = scan_reg ? head_reg[1]  : head_reg[0];
    assign scan_cnt  = scan_reg ? count_reg[1] : count_reg[0];
    assign head_inc  = (scan_head == IDX_W'(LOG_DEPTH - 1)) ? '0 : scan_head + 1'b1;
    assign stale     = rd_data_reg < thresh_reg;

    assign sel_head  = cat_reg ? head_reg[1]  : head_reg[0];
    assign sel_cnt   = cat_reg ? count_reg[1] : count_reg[0];
    assign sel_limit = cat_reg ? lim_qy_reg   : lim_up_reg;

    // Limit clamps to the log depth
    assign grant = (sel_cnt < CNT_W'(LOG_DEPTH)) && (CMP_W'(sel_cnt) < CMP_W'(sel_limit));

    // Tail slot, wraps at the log depth
    assign tail_sum = {1'b0, sel_head} + SUM_W'(sel_cnt);
    assign tail_idx = (tail_sum >= SUM_W'(LOG_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(LOG_DEPTH))
                                                      : IDX_W'(tail_sum);

    // Expiry threshold; borrow means time is still inside the first window
    assign diff = {1'b0, DIFF_W'(now_reg)} - {1'b0, DIFF_W'(window_reg)};

    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Control outputs per state
    always_comb begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = scan_head;
        pop       = 1'b0;
        scan_done = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            swrl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            swrl_pkg::ST_SCAN: begin
                if (exp_en_reg && (scan_cnt != '0)) begin
                    rd_en = 1'b1;
                end else begin
                    scan_done = 1'b1;
                end
            end
            swrl_pkg::ST_CHECK: begin
                if (stale) begin
                    pop = 1'b1;
                    // keep reading while the log still holds entries
                    if (scan_cnt != CNT_W'(1)) begin
                        rd_en  = 1'b1;
                        rd_idx = head_inc;
                    end else begin
                        scan_done = 1'b1;
                    end
                end else begin
                    scan_done = 1'b1;
                end
            end
            swrl_pkg::ST_FINISH: begin
                emit = out_free;
            end
            default: begin
            end
        endcase
    end

    assign wr_en   = emit && grant;
    assign rd_addr = scan_reg ? ADDR_W'(LOG_DEPTH) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);
    assign wr_addr = cat_reg  ? ADDR_W'(LOG_DEPTH) + ADDR_W'(tail_idx) : ADDR_W'(tail_idx);

    // ------------------------------------------------------------------
    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swrl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = swrl_pkg::ST_PREP;
                end
            end
            swrl_pkg::ST_PREP: begin
                state_next = swrl_pkg::ST_SCAN;
            end
            swrl_pkg::ST_SCAN, swrl_pkg::ST_CHECK: begin
                if (rd_en) begin
                    state_next = swrl_pkg::ST_CHECK;
                end else if (scan_reg) begin
                    state_next = swrl_pkg::ST_FINISH;
                end else begin
                    state_next = swrl_pkg::ST_SCAN;
                end
            end
            swrl_pkg::ST_FINISH: begin
                if (emit) begin
                    state_next = swrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swrl_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state, log pointers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swrl_pkg::ST_IDLE;
            window_reg  <= swrl_pkg::WINDOW_MS_RST;
            lim_up_reg  <= swrl_pkg::LIMIT_UPLOAD_RST;
            lim_qy_reg  <= swrl_pkg::LIMIT_QUERY_RST;
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            scan_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid) begin
                case (cfg_index)
                    swrl_pkg::REG_WINDOW_MS:    window_reg <= cfg_data;
                    swrl_pkg::REG_LIMIT_UPLOAD: lim_up_reg <= cfg_data[swrl_pkg::LIMIT_W-1:0];
                    swrl_pkg::REG_LIMIT_QUERY:  lim_qy_reg <= cfg_data[swrl_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // scan pointer: log 0 first, then log 1
            if (state_reg == swrl_pkg::ST_PREP) begin
                scan_reg <= 1'b0;
            end else if (scan_done && !scan_reg) begin
                scan_reg <= 1'b1;
            end

            // pop expired head / append granted stamp
            for (int c = 0; c < 2; c++) begin
                if (pop && (scan_reg == 1'(c))) begin
                    head_reg[c]  <= head_inc;
                    count_reg[c] <= count_reg[c] - 1'b1;
                end else if (wr_en && (cat_reg == 1'(c))) begin
                    count_reg[c] <= count_reg[c] + 1'b1;
                end
            end

            // output word register
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request and result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cat_reg <= s_tuser;
            now_reg <= s_tdata[TIME_BITS-1:0];
        end
        if (state_reg == swrl_pkg::ST_PREP) begin
            exp_en_reg <= !diff[DIFF_W];
            thresh_reg <= diff[TIME_BITS-1:0];
        end
        if (emit) begin
            m_granted_reg <= grant;
            m_count_reg   <= grant ? swrl_pkg::COUNT_OUT_W'(sel_cnt + 1'b1)
                                   : swrl_pkg::COUNT_OUT_W'(sel_cnt);
        end
    end

    // ------------------------------------------------------------------
    // Stamp memory, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stamp_mem[wr_addr] <= now_reg;
        end
        if (rd_en) begin
            rd_data_reg <= stamp_mem[rd_addr];
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, m_count_reg, m_granted_reg};

    // ------------------------------------------------------------------
    // Checks
    `SWRL_ASSERT_IMPL(a_count0_bound, aclk, aresetn, 1'b1, count_reg[0] <= CNT_W'(LOG_DEPTH), "log 0 count above depth")
    `SWRL_ASSERT_IMPL(a_count1_bound, aclk, aresetn, 1'b1, count_reg[1] <= CNT_W'(LOG_DEPTH), "log 1 count above depth")
    `SWRL_ASSERT_IMPL(a_check_nonempty, aclk, aresetn, state_reg == swrl_pkg::ST_CHECK, scan_cnt != '0, "head compare on empty log")
    `SWRL_ASSERT_NEXT(a_accept_prep, aclk, aresetn, s_tvalid && s_tready, state_reg == swrl_pkg::ST_PREP, "request accepted without prep")

endmodule

FILE: tb/swrl_grant_checker.sv
// Watches the rate limiter's channels, predicts each grant decision and compares result words.
`timescale 1ns / 100ps

module swrl_grant_checker
    import swrl_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0] s_tdata,   // [TIME_BITS-1:0] now_ms
    input  logic                           s_tuser,   // [0] category
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [M_DATA_W-1:0]            m_tdata,   // [0] granted, [6:1] count_in_window
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    output int                             error_count,
    output int                             pending
);

    typedef struct packed {
        logic                   granted;
        logic [COUNT_OUT_W-1:0] count;
    } grant_t;

    // Shadow copy of both timestamp logs and the registers
    logic [TIME_BITS-1:0]  stamp_log [2][LOG_DEPTH];
    int unsigned           head_pos [2];
    int unsigned           fill [2];
    logic [CFG_DATA_W-1:0] window_ms;
    logic [LIMIT_W-1:0]    limit_upload;
    logic [LIMIT_W-1:0]    limit_query;

    grant_t expected_grants [$];

    // Pop stamps that fell out of the window; stops at the first kept head
    function automatic void expire_stamps(input int c, input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] threshold;
        if (now < window_ms)
            return;
        threshold = now - window_ms;
        while (fill[c] > 0 && stamp_log[c][head_pos[c]] < threshold) begin
            head_pos[c] = (head_pos[c] + 1) % LOG_DEPTH;
            fill[c]--;
        end
    endfunction

    // Decide one request and update the shadow logs
    function automatic grant_t admit_request(input logic cat, input logic [TIME_BITS-1:0] now);
        int     c;
        int     lim;
        grant_t g;
        c = cat;
        expire_stamps(0, now);
        expire_stamps(1, now);
        lim = cat ? limit_query : limit_upload;
        if (lim > LOG_DEPTH)
            lim = LOG_DEPTH;
        g.granted = fill[c] < lim;
        if (g.granted) begin
            stamp_log[c][(head_pos[c] + fill[c]) % LOG_DEPTH] = now;
            fill[c]++;
        end
        g.count = COUNT_OUT_W'(fill[c]);
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            window_ms    = WINDOW_MS_RST;
            limit_upload = LIMIT_UPLOAD_RST;
            limit_query  = LIMIT_QUERY_RST;
            head_pos     = '{0, 0};
            fill         = '{0, 0};
            expected_grants.delete();
            pending      = 0;
            error_count  = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW_MS:    window_ms = cfg_data;
                    REG_LIMIT_UPLOAD: limit_upload = cfg_data[LIMIT_W-1:0];
                    REG_LIMIT_QUERY:  limit_query = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // result words against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch("unexpected result word", 0, m_tdata);
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tdata[0] !== want.granted)
                        report_mismatch("granted", want.granted, m_tdata[0]);
                    if (m_tdata[COUNT_OUT_W:1] !== want.count)
                        report_mismatch("count_in_window", want.count, m_tdata[COUNT_OUT_W:1]);
                    if (m_tdata[M_DATA_W-1:COUNT_OUT_W+1] !== '0)
                        report_mismatch("padding", 0, m_tdata[M_DATA_W-1:COUNT_OUT_W+1]);
                end
            end
            // accepted requests
            if (s_tvalid && s_tready) begin
                want = admit_request(s_tuser, s_tdata[TIME_BITS-1:0]);
                expected_grants = {expected_grants, want};
            end
            pending = expected_grants.size();
        end
    end

endmodule

FILE: tb/tb_sliding_window_rate_limiter.sv
// Top of the rate limiter testbench: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 100ps

module tb_sliding_window_rate_limiter;
    import swrl_pkg::*;

    localparam int TIME_BITS = TIME_BITS_DEF;
    localparam int S_DATA_W  = ((TIME_BITS + 7) / 8) * 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;   // no register behind it
    localparam logic [TIME_BITS-1:0]   TIME_MAX  = '1;

    localparam int DRAIN_CYCLES     = 80;    // longest scan plus margin
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AT_ITEM     = 900;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;      // [TIME_BITS-1:0] now_ms
    logic                   s_tuser   = 1'b0;    // [0] category
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [M_DATA_W-1:0]    m_tdata;             // [0] granted, [6:1] count_in_window
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     error_count;
    int                     pending;

    int                     items_sent = 0;
    logic [TIME_BITS-1:0]   clock_ms   = '0;

    sliding_window_rate_limiter uut (.*);

    swrl_grant_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb_sliding_window_rate_limiter: errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Offer one request word and hold it until accepted
    task automatic send_request(input logic cat, input logic [TIME_BITS-1:0] now);
        int gap;
        s_tuser  <= cat;
        s_tdata  <= S_DATA_W'(now);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and let every predicted result come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        // let the checker count any word accepted before the offer stopped
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] win, input logic [LIMIT_W-1:0] lu,
                             input logic [LIMIT_W-1:0] lq, input bit touch_spare);
        write_reg(REG_WINDOW_MS, win);
        write_reg(REG_LIMIT_UPLOAD, CFG_DATA_W'(lu));
        write_reg(REG_LIMIT_QUERY, CFG_DATA_W'(lq));
        if (touch_spare)
            write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // One setting of the registers followed by a random request stream
    task automatic run_phase(input logic [CFG_DATA_W-1:0] win, input logic [LIMIT_W-1:0] lu,
                             input logic [LIMIT_W-1:0] lq, input logic [TIME_BITS-1:0] base,
                             input int max_step, input int n_items, input bit touch_spare,
                             input bit pause_mid);
        int r;
        int step;
        wait_all_results();
        configure(win, lu, lq, touch_spare);
        if (base > clock_ms)
            clock_ms = base;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                // small step back in time
                step = $urandom_range(1, 15);
                if (clock_ms >= step)
                    clock_ms = clock_ms - step;
            end else begin
                step = (r < 9) ? $urandom_range(0, 64 * max_step) : $urandom_range(0, max_step);
                if (TIME_MAX - clock_ms < step)
                    clock_ms = TIME_MAX;
                else
                    clock_ms = clock_ms + step;
            end
            send_request(1'($urandom_range(0, 1)), clock_ms);
            if (pause_mid && i == n_items / 2)
                wait_all_results();
        end
    endtask

    // Result side: random back-pressure plus one long hold
    initial begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                if (hold == 0)
                    m_tready <= 1'b1;
            end else if (!long_done && items_sent >= HOLD_AT_ITEM) begin
                long_done = 1;
                hold = LONG_HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                hold = gap_len();
                if (hold > 0)
                    m_tready <= 1'b0;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits, early time: nothing expires
        repeat (10) send_request(1'b0, '0);
        repeat (2) send_request(1'b1, 48'd59999);
        send_request(1'b0, 48'd60000);      // stamp equal to threshold is kept
        send_request(1'b0, 48'd60001);      // whole upload log expires
        send_request(1'b1, 48'd60001);
        send_request(1'b0, 48'd100);        // back below the window

        // short window, upload blocked, query at full depth
        wait_all_results();
        configure(32'd10, 6'd0, 6'd32, 1'b0);
        send_request(1'b1, 48'd1000);
        send_request(1'b1, 48'd1015);
        send_request(1'b1, 48'd1012);       // time runs backwards
        send_request(1'b1, 48'd1024);       // kept head shields the older stamp
        send_request(1'b0, TIME_MAX);       // throttled, flushes both logs
        send_request(1'b1, 48'd2000);
        clock_ms = 48'd2000;

        run_phase(WINDOW_MS_RST, LIMIT_UPLOAD_RST, LIMIT_QUERY_RST, '0, 3000, 200, 0, 0);
        run_phase(32'd100, 6'd32, 6'd32, '0, 8, 220, 0, 1);
        run_phase(32'hFFFF_FFFF, 6'd63, 6'd5, '0, 1 << 20, 180, 0, 0);
        run_phase(32'd0, 6'd1, 6'd0, '0, 2, 180, 1, 0);
        run_phase(32'd1, 6'd33, 6'd2, '0, 1, 180, 0, 0);
        run_phase($urandom_range(20, 500), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  {2'b01, 14'($urandom), 32'($urandom)}, 40, 260, 0, 0);
        run_phase(32'd1000, 6'd0, 6'd32, '0, 60, 200, 0, 0);
        run_phase($urandom_range(20, 500), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  48'hFFFF_FFF0_0000, 30, 280, 0, 0);

        wait_all_results();
        if (error_count == 0 && pending == 0)
            $display("tb_sliding_window_rate_limiter: clean");
        else
            $display("tb_sliding_window_rate_limiter: errors");
        $finish;
    end

endmodule
